[rtl/i2c_master_write_engine_macros.svh]
// assertion helpers shared by the engine modules
`ifndef I2C_MASTER_WRITE_ENGINE_MACROS_SVH
`define I2C_MASTER_WRITE_ENGINE_MACROS_SVH

`ifndef SYNTH
// checked property with reset masking
`define I2CW_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked property that also looks at reset itself
`define I2CW_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I2CW_ASSERT(label, clk, rstn, prop, msg)
`define I2CW_ASSERT_RST(label, clk, prop, msg)
`endif

`endif

[rtl/i2cw_pkg.sv]
`timescale 1ns / 1ps

package i2cw_pkg;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_DATA  = 2'd2,
        MODE_RSVD  = 2'd3
    } mode_t;

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_START_A = 11'b000_0000_0010,
        ST_START_B = 11'b000_0000_0100,
        ST_START_C = 11'b000_0000_1000,
        ST_BIT_HI  = 11'b000_0001_0000,
        ST_BIT_LO  = 11'b000_0010_0000,
        ST_ACK_HI  = 11'b000_0100_0000,
        ST_ACK_LO  = 11'b000_1000_0000,
        ST_HOLD    = 11'b001_0000_0000,
        ST_FIN_A   = 11'b010_0000_0000,
        ST_FIN_B   = 11'b100_0000_0000
    } step_t;

    localparam logic [0:0]  CFG_STRICT = 1'b0;
    localparam logic [0:0]  CFG_WAIT   = 1'b1;
    localparam logic [15:0] WAIT_RESET = 16'd100;
    localparam int          STATUS_W   = 16;

    typedef struct packed {
        mode_t      mode;
        logic [6:0] target_address;
        logic [7:0] data_byte;
        logic       is_last;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic        strict_mode;
        logic [15:0] wait_ticks;
    } cfg_t;

    typedef struct packed {
        logic                scl_low;
        logic                sda_low;
        logic                slot_free;
        logic                accepted;
        logic                packet_done;
        logic [STATUS_W-1:0] packet_status;
    } result_t;

endpackage

[rtl/i2cw_seq.sv]
`timescale 1ns / 1ps

module i2cw_seq #(
    parameter int COUNT_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  i2cw_pkg::in_item_t item,
    input  i2cw_pkg::cfg_t     cfg,
    output i2cw_pkg::result_t  result
);
    import i2cw_pkg::*;

`include "i2c_master_write_engine_macros.svh"

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    step_t                 step_reg,       step_next;
    logic [15:0]           phase_reg,      phase_next;
    logic [2:0]            bitpos_reg,     bitpos_next;
    logic [7:0]            shift_reg,      shift_next;
    logic [7:0]            held_byte_reg,  held_byte_next;
    logic                  held_valid_reg, held_valid_next;
    logic                  held_last_reg,  held_last_next;
    logic                  cur_last_reg,   cur_last_next;
    logic [COUNT_BITS-1:0] nack_reg,       nack_next;
    logic [COUNT_BITS-1:0] idx_reg,        idx_next;
    logic                  drop_reg,       drop_next;
    logic                  addr_phase_reg, addr_phase_next;
    logic                  got_nack_reg,   got_nack_next;

    logic [15:0]           wt;
    logic [16:0]           phase_inc;
    logic [COUNT_BITS-1:0] idx_inc;
    logic [COUNT_BITS-1:0] nack_inc;
    logic                  want_data;
    logic                  stop;
    logic                  acc;
    logic                  done;
    logic                  tx_bit;
    logic                  scl_l;
    logic                  sda_l;
    logic [STATUS_W-1:0]   nack_clip;

    assign wt        = (cfg.wait_ticks == 16'd0) ? 16'd1 : cfg.wait_ticks;
    assign phase_inc = {1'b0, phase_reg} + 17'd1;
    assign idx_inc   = (idx_reg == CNT_MAX) ? idx_reg : idx_reg + 1'b1;
    assign nack_inc  = (nack_reg == CNT_MAX) ? nack_reg : nack_reg + 1'b1;
    assign want_data = (step_reg != ST_IDLE) && !cur_last_reg && !held_valid_reg;

    // status port is narrower than the counters at large COUNT_BITS
    generate
        if (COUNT_BITS > STATUS_W) begin : g_clip
            assign nack_clip = (|nack_reg[COUNT_BITS-1:STATUS_W]) ? '1
                                                                   : nack_reg[STATUS_W-1:0];
        end else begin : g_ext
            assign nack_clip = STATUS_W'(nack_reg);
        end
    endgenerate

    always_comb begin
        step_next       = step_reg;
        phase_next      = phase_reg;
        bitpos_next     = bitpos_reg;
        shift_next      = shift_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        held_last_next  = held_last_reg;
        cur_last_next   = cur_last_reg;
        nack_next       = nack_reg;
        idx_next        = idx_reg;
        drop_next       = drop_reg;
        addr_phase_next = addr_phase_reg;
        got_nack_next   = got_nack_reg;
        stop            = 1'b0;
        acc             = 1'b0;
        done            = 1'b0;

        case (item.mode)
            MODE_TICK: begin
                if (step_reg == ST_HOLD) begin
                    if (held_valid_reg) begin
                        shift_next      = held_byte_reg;
                        cur_last_next   = held_last_reg;
                        held_valid_next = 1'b0;
                        bitpos_next     = 3'd7;
                        step_next       = ST_BIT_HI;
                        phase_next      = '0;
                    end
                end else if (step_reg != ST_IDLE) begin
                    if (phase_inc < {1'b0, wt}) begin
                        phase_next = phase_inc[15:0];
                    end else begin
                        phase_next = '0;
                        case (step_reg)
                            ST_START_A: step_next = ST_START_B;
                            ST_START_B: step_next = ST_START_C;
                            ST_START_C: begin
                                bitpos_next = 3'd7;
                                step_next   = ST_BIT_HI;
                            end
                            ST_BIT_HI: step_next = ST_BIT_LO;
                            ST_BIT_LO: begin
                                if (bitpos_reg == 3'd0) begin
                                    step_next = ST_ACK_HI;
                                end else begin
                                    bitpos_next = bitpos_reg - 3'd1;
                                    step_next   = ST_BIT_HI;
                                end
                            end
                            ST_ACK_HI: begin
                                got_nack_next = item.sda_in;
                                step_next     = ST_ACK_LO;
                            end
                            ST_ACK_LO: begin
                                if (addr_phase_reg) begin
                                    addr_phase_next = 1'b0;
                                    if (got_nack_reg) begin
                                        nack_next = COUNT_BITS'(1);
                                        stop      = 1'b1;
                                    end
                                end else begin
                                    idx_next = idx_inc;
                                    if (got_nack_reg) begin
                                        if (cfg.strict_mode) begin
                                            nack_next = idx_inc;
                                            stop      = 1'b1;
                                        end else begin
                                            nack_next = nack_inc;
                                        end
                                    end
                                end
                                if (stop) begin
                                    // bytes still to come get swallowed up to the last one
                                    drop_next = !(cur_last_reg || (held_valid_reg && held_last_reg));
                                    held_valid_next = 1'b0;
                                    step_next       = ST_FIN_A;
                                end else if (cur_last_reg) begin
                                    step_next = ST_FIN_A;
                                end else if (held_valid_reg) begin
                                    shift_next      = held_byte_reg;
                                    cur_last_next   = held_last_reg;
                                    held_valid_next = 1'b0;
                                    bitpos_next     = 3'd7;
                                    step_next       = ST_BIT_HI;
                                end else begin
                                    step_next = ST_HOLD;
                                end
                            end
                            ST_FIN_A: step_next = ST_FIN_B;
                            ST_FIN_B: begin
                                step_next = ST_IDLE;
                                done      = 1'b1;
                            end
                            default: step_next = ST_IDLE;
                        endcase
                    end
                end
            end
            MODE_START: begin
                if (step_reg == ST_IDLE) begin
                    acc             = 1'b1;
                    drop_next       = 1'b0;
                    shift_next      = {item.target_address, 1'b0};
                    cur_last_next   = item.is_last;
                    addr_phase_next = 1'b1;
                    got_nack_next   = 1'b0;
                    nack_next       = '0;
                    idx_next        = '0;
                    held_valid_next = 1'b0;
                    held_last_next  = 1'b0;
                    bitpos_next     = 3'd7;
                    phase_next      = '0;
                    step_next       = ST_START_A;
                end
            end
            MODE_DATA: begin
                if (drop_reg) begin
                    acc = 1'b1;
                    if (item.is_last) begin
                        drop_next = 1'b0;
                    end
                end else if (want_data) begin
                    acc             = 1'b1;
                    held_byte_next  = item.data_byte;
                    held_last_next  = item.is_last;
                    held_valid_next = 1'b1;
                end
            end
            default: ;
        endcase

        // line levels follow the state after this item
        tx_bit = shift_next[bitpos_next];
        scl_l  = 1'b0;
        sda_l  = 1'b0;
        case (step_next)
            ST_START_B: sda_l = 1'b1;
            ST_START_C, ST_ACK_LO, ST_HOLD, ST_FIN_A: begin
                scl_l = 1'b1;
                sda_l = 1'b1;
            end
            ST_BIT_HI: sda_l = ~tx_bit;
            ST_BIT_LO: begin
                scl_l = 1'b1;
                sda_l = ~tx_bit;
            end
            ST_FIN_B: sda_l = 1'b1;
            default: ;
        endcase

        result.scl_low       = scl_l;
        result.sda_low       = sda_l;
        result.slot_free     = drop_next
                               || ((step_next != ST_IDLE) && !cur_last_next && !held_valid_next);
        result.accepted      = acc;
        result.packet_done   = done;
        result.packet_status = done ? nack_clip : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg       <= ST_IDLE;
            phase_reg      <= '0;
            bitpos_reg     <= '0;
            shift_reg      <= '0;
            held_valid_reg <= 1'b0;
            held_last_reg  <= 1'b0;
            cur_last_reg   <= 1'b0;
            nack_reg       <= '0;
            idx_reg        <= '0;
            drop_reg       <= 1'b0;
            addr_phase_reg <= 1'b0;
            got_nack_reg   <= 1'b0;
        end else if (step_en) begin
            step_reg       <= step_next;
            phase_reg      <= phase_next;
            bitpos_reg     <= bitpos_next;
            shift_reg      <= shift_next;
            held_valid_reg <= held_valid_next;
            held_last_reg  <= held_last_next;
            cur_last_reg   <= cur_last_next;
            nack_reg       <= nack_next;
            idx_reg        <= idx_next;
            drop_reg       <= drop_next;
            addr_phase_reg <= addr_phase_next;
            got_nack_reg   <= got_nack_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            held_byte_reg <= held_byte_next;
        end
    end

    `I2CW_ASSERT(a_idle_phase_clear, aclk, aresetn, (step_reg == ST_IDLE) |-> (phase_reg == '0), "phase count running while idle")
    `I2CW_ASSERT(a_drop_slot_empty, aclk, aresetn, drop_reg |-> !held_valid_reg, "slot full while dropping")
    `I2CW_ASSERT(a_start_opens, aclk, aresetn, (step_en && item.mode == MODE_START && step_reg == ST_IDLE) |=> (step_reg == ST_START_A), "start item did not open a packet")

endmodule

[rtl/i2cw_obuf.sv]
`timescale 1ns / 1ps

module i2cw_obuf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  i2cw_pkg::result_t in_res,
    output logic              out_valid,
    input  logic              out_ready,
    output i2cw_pkg::result_t out_res
);
    import i2cw_pkg::*;

`include "i2c_master_write_engine_macros.svh"

    logic    valid_reg;
    result_t res_reg;

    // a new item may enter while the held result leaves in the same cycle
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            res_reg <= in_res;
        end
    end

    `I2CW_ASSERT_RST(a_reset_empty, aclk, !aresetn |=> !valid_reg, "result register not empty after reset")
    `I2CW_ASSERT(a_fill, aclk, aresetn, (in_valid && in_ready) |=> valid_reg, "taken item left no result")
    `I2CW_ASSERT(a_done_status, aclk, aresetn, (valid_reg && !res_reg.packet_done) |-> (res_reg.packet_status == '0), "status set without packet end")

endmodule

[rtl/i2c_master_write_engine.sv]
`timescale 1ns / 1ps

// I2C write master driven by a stream of items: tick, start-with-address and
// data-byte items each produce exactly one result (SCL/SDA drive levels, slot
// state, accept flag, packet end and status). An item is taken every clock
// cycle when the result register is empty or its result is being taken; the
// result appears in that register in the cycle after its item, so the sustained
// rate is one item per cycle, set only by the output register handshake.
// Bus timing is counted in tick items, wait_ticks per phase.
module i2c_master_write_engine #(
    parameter int COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [6:0]  s_target_address,
    input  logic [7:0]  s_data_byte,
    input  logic        s_is_last,
    input  logic        s_sda_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_low,
    output logic        m_sda_low,
    output logic        m_slot_free,
    output logic        m_accepted,
    output logic        m_packet_done,
    output logic [15:0] m_packet_status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import i2cw_pkg::*;

    logic        strict_reg;
    logic [15:0] wait_reg;
    cfg_t        cfg;
    in_item_t    item;
    result_t     step_res;
    result_t     out_res;
    logic        in_fire;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strict_reg <= 1'b0;
            wait_reg   <= WAIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_STRICT: strict_reg <= cfg_data[0];
                CFG_WAIT:   wait_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.strict_mode = strict_reg;
    assign cfg.wait_ticks  = wait_reg;

    assign item.mode           = mode_t'(s_mode);
    assign item.target_address = s_target_address;
    assign item.data_byte      = s_data_byte;
    assign item.is_last        = s_is_last;
    assign item.sda_in         = s_sda_in;

    assign in_fire = s_valid && s_ready;

    i2cw_seq #(
        .COUNT_BITS(COUNT_BITS)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (in_fire),
        .item    (item),
        .cfg     (cfg),
        .result  (step_res)
    );

    i2cw_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_res    (step_res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_scl_low       = out_res.scl_low;
    assign m_sda_low       = out_res.sda_low;
    assign m_slot_free     = out_res.slot_free;
    assign m_accepted      = out_res.accepted;
    assign m_packet_done   = out_res.packet_done;
    assign m_packet_status = out_res.packet_status;

endmodule
